// File: design/point_in_area_test_defines.svh
// Assertion macros for the point-in-area test block.
// The asserting module provides clk and rst_n in its scope.
`ifndef POINT_IN_AREA_TEST_DEFINES_SVH
`define POINT_IN_AREA_TEST_DEFINES_SVH
`ifndef SYNTHESIS
`define PIA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("point_in_area_test: same-cycle check failed");
`define PIA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("point_in_area_test: next-cycle check failed");
`else
`define PIA_ASSERT_IMP(lbl, ante, cons)
`define PIA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: design/pia_pkg.sv
package pia_pkg;

  // Fixed field widths of the configuration registers.
  localparam int SHAPE_W    = 3;
  localparam int RADIUS_W   = 23;
  localparam int AIM_W      = 24;
  localparam int ANGLE_W    = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef logic [SHAPE_W-1:0]   shape_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Area shape codes.
  localparam shape_t SHAPE_CIRCLE = 3'd0;
  localparam shape_t SHAPE_SQUARE = 3'd1;
  localparam shape_t SHAPE_RECT   = 3'd2;
  localparam shape_t SHAPE_SECTOR = 3'd3;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_SHAPE  = 3'd0;
  localparam cfg_idx_t CFG_RADIUS = 3'd1;
  localparam cfg_idx_t CFG_WIDTH  = 3'd2;
  localparam cfg_idx_t CFG_HEIGHT = 3'd3;
  localparam cfg_idx_t CFG_AIM_X  = 3'd4;
  localparam cfg_idx_t CFG_AIM_Y  = 3'd5;
  localparam cfg_idx_t CFG_ANGLE  = 3'd6;

  // Angles in sixteenths of a degree.
  localparam logic [ANGLE_W-1:0] ANGLE_FULL = 13'd5760;
  localparam logic [ANGLE_W-1:0] ANGLE_HALF = 13'd2880;

  // Cosine series constants in Q30.
  localparam logic [31:0] STEP_Q30  = 32'd585635;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [2:0]  LAST_TERM = 3'd5;

  // Sequencer states of the cosine unit.
  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_X    = 10'b00_0000_0010,
    ST_U1   = 10'b00_0000_0100,
    ST_U2   = 10'b00_0000_1000,
    ST_P1   = 10'b00_0001_0000,
    ST_P2   = 10'b00_0010_0000,
    ST_DIV  = 10'b00_0100_0000,
    ST_T    = 10'b00_1000_0000,
    ST_C1   = 10'b01_0000_0000,
    ST_C2   = 10'b10_0000_0000
  } seq_state_t;

  // Decision bits that ride along the pipeline after the shape tests.
  typedef struct packed {
    logic res_fix;
    logic need;
    logic dot_nn;
  } carry_t;

  // The Horner divisors are 132, 90, 56, 30, 12 and 2. Each is split into a
  // power of two, taken off by a right shift, and an odd factor, divided by
  // a reciprocal multiply that is exact for every dividend below 2^31.
  function automatic logic [1:0] horner_pre(input logic [2:0] k);
    logic [1:0] s;
    unique case (k)
      3'd0:    s = 2'd2;
      3'd1:    s = 2'd1;
      3'd2:    s = 2'd3;
      3'd3:    s = 2'd1;
      3'd4:    s = 2'd2;
      default: s = 2'd1;
    endcase
    return s;
  endfunction

  // Rounded-up reciprocal of the odd factor.
  function automatic logic [31:0] horner_recip(input logic [2:0] k);
    logic [31:0] m;
    unique case (k)
      3'd0:    m = 32'd4164816772;
      3'd1:    m = 32'd3054198967;
      3'd2:    m = 32'd2454267027;
      3'd3:    m = 32'd2290649225;
      3'd4:    m = 32'd2863311531;
      default: m = 32'd2147483648;
    endcase
    return m;
  endfunction

  // Right shift that follows the reciprocal multiply.
  function automatic logic [5:0] horner_post(input logic [2:0] k);
    logic [5:0] s;
    unique case (k)
      3'd0:    s = 6'd37;
      3'd1:    s = 6'd37;
      3'd2:    s = 6'd34;
      3'd3:    s = 6'd35;
      3'd4:    s = 6'd33;
      default: s = 6'd31;
    endcase
    return s;
  endfunction

endpackage

// File: design/point_in_area_test.sv
// Channel | Ports                                          | Direction
// input   | in_valid, in_ready, in_origin_*, in_target_*   | into block
// result  | out_valid, out_ready, out_inside_res           | out of block
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data      | into block
//
// One item enters per cycle while the cosine unit is idle and no result
// stalls. The pipeline depth is set by the wide exact compare of the sector
// test. After reset and after every configuration write, the cosine unit
// runs through 6 Horner terms, each two multiplies; no item and no write is
// taken meanwhile. A stalled result holds the whole pipeline.
`include "point_in_area_test_defines.svh"

module point_in_area_test #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_BITS-1:0]          in_origin_x,
  input  logic signed [COORD_BITS-1:0]          in_origin_y,
  input  logic signed [COORD_BITS-1:0]          in_target_x,
  input  logic signed [COORD_BITS-1:0]          in_target_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_inside_res,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pia_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pia_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import pia_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int DW    = CW + 1;
  localparam int RW    = RADIUS_W;
  localparam int SW    = RW + 1;
  localparam int MW    = (CW > RW) ? CW : RW;
  localparam int XW    = (DW > SW) ? DW : SW;
  localparam int SQW   = 2 * RW;
  localparam int T2W   = SQW + 1;
  localparam int PW    = SW + AIM_W;
  localparam int DTW   = PW + 1;
  localparam int HW    = 24;
  localparam int LW    = 2 * HW;
  localparam int WW    = 4 * HW;
  localparam int CQW   = 31;
  localparam int CPW   = HW + CQW;
  localparam int RHW   = WW + CQW;
  localparam int NSTG  = 10;
  localparam longint unsigned TINY_MAX = (64'd1 << (2 * FRAC_BITS)) / 64'd100000000;
  localparam logic signed [AIM_W-1:0] AIM_UNIT = AIM_W'(64'd1 << FRAC_BITS);
  localparam logic [LW-1:0]           D2_UNIT  = LW'(64'd1 << (2 * FRAC_BITS));

  // Configuration registers.
  shape_t                    shape_r;
  logic [RW-1:0]             radius_r, width_r, height_r;
  logic signed [AIM_W-1:0]   aim_x_r, aim_y_r;
  logic [ANGLE_W-1:0]        angle_r;
  logic                      cfg_fire, busy;

  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r  <= SHAPE_CIRCLE;
      radius_r <= '0;
      width_r  <= '0;
      height_r <= '0;
      aim_x_r  <= AIM_W'(256);
      aim_y_r  <= '0;
      angle_r  <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        CFG_SHAPE:  shape_r  <= cfg_data[SHAPE_W-1:0];
        CFG_RADIUS: radius_r <= cfg_data[RW-1:0];
        CFG_WIDTH:  width_r  <= cfg_data[RW-1:0];
        CFG_HEIGHT: height_r <= cfg_data[RW-1:0];
        CFG_AIM_X:  aim_x_r  <= cfg_data[AIM_W-1:0];
        CFG_AIM_Y:  aim_y_r  <= cfg_data[AIM_W-1:0];
        CFG_ANGLE:  angle_r  <= cfg_data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Values derived from the configuration; they settle long before the
  // cosine unit releases the input.
  logic [AIM_W-1:0]        amx, amy;
  logic [LW-1:0]           asqx_r, asqy_r, d2raw, d2_r;
  logic signed [AIM_W-1:0] aimx_eff_r, aimy_eff_r;
  logic [SQW-1:0]          rsq_r;
  logic [RW-1:0]           half_full_r;
  logic                    aim_tiny, wide, neg;

  assign amx      = AIM_W'(aim_x_r[AIM_W-1] ? -aim_x_r : aim_x_r);
  assign amy      = AIM_W'(aim_y_r[AIM_W-1] ? -aim_y_r : aim_y_r);
  assign d2raw    = asqx_r + asqy_r;
  assign aim_tiny = d2raw <= LW'(TINY_MAX);
  assign wide     = angle_r >= ANGLE_FULL;
  assign neg      = angle_r > ANGLE_HALF;

  always_ff @(posedge clk) begin
    asqx_r      <= LW'(amx) * LW'(amx);
    asqy_r      <= LW'(amy) * LW'(amy);
    d2_r        <= aim_tiny ? D2_UNIT : d2raw;
    aimx_eff_r  <= aim_tiny ? AIM_UNIT : aim_x_r;
    aimy_eff_r  <= aim_tiny ? '0 : aim_y_r;
    rsq_r       <= SQW'(radius_r) * SQW'(radius_r);
    half_full_r <= (width_r > height_r) ? (width_r >> 1) : (height_r >> 1);
  end

  // Cosine unit: one shared multiplier. Each Horner division by a constant
  // is a shift followed by a reciprocal multiply.
  seq_state_t         state_r, state_nxt;
  logic [63:0]        mul_r;
  logic [31:0]        mul_a, mul_b, u_r, num_r, quot;
  logic [30:0]        t_r;
  logic [CQW-1:0]     csq_r;
  logic [2:0]         k_r;
  logic [ANGLE_W-1:0] q_sel;

  assign busy   = state_r != ST_IDLE;
  assign q_sel  = neg ? (ANGLE_FULL - angle_r) : angle_r;
  assign quot   = 32'(mul_r >> horner_post(k_r));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_X: begin
        mul_a = 32'(q_sel);
        mul_b = STEP_Q30;
      end
      ST_U1: begin
        mul_a = mul_r[31:0];
        mul_b = mul_r[31:0];
      end
      ST_P1: begin
        mul_a = u_r;
        mul_b = 32'(t_r);
      end
      ST_DIV: begin
        mul_a = num_r;
        mul_b = horner_recip(k_r);
      end
      ST_C1: begin
        mul_a = 32'(t_r);
        mul_b = 32'(t_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (cfg_fire) state_nxt = ST_X;
      ST_X:    state_nxt = ST_U1;
      ST_U1:   state_nxt = ST_U2;
      ST_U2:   state_nxt = ST_P1;
      ST_P1:   state_nxt = ST_P2;
      ST_P2:   state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_T;
      ST_T:    state_nxt = (k_r == LAST_TERM) ? ST_C1 : ST_P1;
      ST_C1:   state_nxt = ST_C2;
      ST_C2:   state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // The unit starts a run on its own out of reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_X;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_U2) k_r <= '0;
      else if (state_r == ST_T) k_r <= k_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= 64'(mul_a) * 64'(mul_b);
    unique case (state_r)
      ST_U2: begin
        u_r <= mul_r[61:30];
        t_r <= ONE_Q30;
      end
      ST_P2: num_r <= mul_r[61:30] >> horner_pre(k_r);
      ST_T:  t_r   <= (quot >= 32'(ONE_Q30)) ? '0 : (ONE_Q30 - quot[30:0]);
      ST_C2: csq_r <= mul_r[60:30];
      default: ;
    endcase
  end

  // Pipeline control: every stage moves when the result register is free.
  logic [NSTG-1:0] vld_r;
  logic            en, in_fire;

  assign en        = !vld_r[NSTG-1] || out_ready;
  assign in_ready  = en && !busy;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_fire};
    end
  end

  // Stage datapath registers.
  logic signed [DW-1:0]  dx1_r, dy1_r;
  logic [CW-1:0]         ax2_r, ay2_r;
  logic signed [SW-1:0]  dxs2_r, dys2_r;
  logic signed [XW-1:0]  dx1_ext, dy1_ext;
  logic [MW-1:0]         ax_ext, ay_ext, rad_ext;
  logic [RW-1:0]         axt, ayt;
  logic                  in_r3_r, sqf3_r, rect3_r, in_r4_r, sqf4_r, rect4_r;
  logic [SQW-1:0]        sqx3_r, sqy3_r;
  logic signed [PW-1:0]  px3_r, py3_r;
  logic [T2W-1:0]        t2_4_r;
  logic signed [DTW-1:0] dot4_r;
  logic                  circle, t2tiny, base;
  carry_t                c5, c5_r, c6_r, c7_r, c8_r, c9_r;
  logic [LW-1:0]         dabs5_r, t2_5_r;
  logic [LW-1:0]         dll_r, dlh_r, dhh_r, tll_r, tlh_r, thl_r, thh_r;
  logic [WW-1:0]         dsq7_r, td7_r, dsq8_r;
  logic [CPW-1:0]        cp_r [4];
  logic [RHW-1:0]        lhs9_r, rhs9_r;
  logic                  angle_ok;

  // Stage 1: offsets from the origin.
  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r <= DW'(in_target_x) - DW'(in_origin_x);
      dy1_r <= DW'(in_target_y) - DW'(in_origin_y);
    end
  end

  // Stage 2: magnitudes, and short signed offsets for the dot product.
  assign dx1_ext = XW'(dx1_r);
  assign dy1_ext = XW'(dy1_r);

  always_ff @(posedge clk) begin
    if (en) begin
      ax2_r  <= CW'(dx1_r[DW-1] ? -dx1_r : dx1_r);
      ay2_r  <= CW'(dy1_r[DW-1] ? -dy1_r : dy1_r);
      dxs2_r <= dx1_ext[SW-1:0];
      dys2_r <= dy1_ext[SW-1:0];
    end
  end

  // Stage 3: bound compares and the first products. Within the radius bound
  // the short operands are exact; outside it nothing downstream matters.
  assign ax_ext  = MW'(ax2_r);
  assign ay_ext  = MW'(ay2_r);
  assign rad_ext = MW'(radius_r);
  assign axt     = ax_ext[RW-1:0];
  assign ayt     = ay_ext[RW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      in_r3_r <= (ax_ext <= rad_ext) && (ay_ext <= rad_ext);
      sqf3_r  <= (ax_ext <= MW'(half_full_r)) && (ay_ext <= MW'(half_full_r));
      rect3_r <= (ax_ext <= MW'(width_r >> 1)) && (ay_ext <= MW'(height_r >> 1));
      sqx3_r  <= SQW'(axt) * SQW'(axt);
      sqy3_r  <= SQW'(ayt) * SQW'(ayt);
      px3_r   <= PW'(dxs2_r) * PW'(aimx_eff_r);
      py3_r   <= PW'(dys2_r) * PW'(aimy_eff_r);
    end
  end

  // Stage 4: squared length and dot product.
  always_ff @(posedge clk) begin
    if (en) begin
      t2_4_r  <= T2W'(sqx3_r) + T2W'(sqy3_r);
      dot4_r  <= DTW'(px3_r) + DTW'(py3_r);
      in_r4_r <= in_r3_r;
      sqf4_r  <= sqf3_r;
      rect4_r <= rect3_r;
    end
  end

  // Stage 5: shape decision; a sector item that is still open needs the
  // exact angle compare at the end.
  assign circle = in_r4_r && (t2_4_r <= T2W'(rsq_r));
  assign t2tiny = t2_4_r <= T2W'(TINY_MAX);

  always_comb begin
    case (shape_r)
      SHAPE_CIRCLE: base = circle;
      SHAPE_SQUARE: base = (radius_r != '0) ? in_r4_r : sqf4_r;
      SHAPE_RECT:   base = rect4_r;
      SHAPE_SECTOR: base = circle && (t2tiny || wide);
      default:      base = 1'b0;
    endcase
    c5.res_fix = base;
    c5.need    = (shape_r == SHAPE_SECTOR) && circle && !t2tiny && !wide;
    c5.dot_nn  = !dot4_r[DTW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c5_r    <= c5;
      dabs5_r <= LW'(dot4_r[DTW-1] ? -dot4_r : dot4_r);
      t2_5_r  <= LW'(t2_4_r);
    end
  end

  // Stage 6: partial products of dot squared and of the two lengths.
  always_ff @(posedge clk) begin
    if (en) begin
      c6_r  <= c5_r;
      dll_r <= LW'(dabs5_r[HW-1:0]) * LW'(dabs5_r[HW-1:0]);
      dlh_r <= LW'(dabs5_r[HW-1:0]) * LW'(dabs5_r[LW-1:HW]);
      dhh_r <= LW'(dabs5_r[LW-1:HW]) * LW'(dabs5_r[LW-1:HW]);
      tll_r <= LW'(t2_5_r[HW-1:0]) * LW'(d2_r[HW-1:0]);
      tlh_r <= LW'(t2_5_r[HW-1:0]) * LW'(d2_r[LW-1:HW]);
      thl_r <= LW'(t2_5_r[LW-1:HW]) * LW'(d2_r[HW-1:0]);
      thh_r <= LW'(t2_5_r[LW-1:HW]) * LW'(d2_r[LW-1:HW]);
    end
  end

  // Stage 7: sum the partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      c7_r   <= c6_r;
      dsq7_r <= (WW'(dhh_r) << LW) + (WW'(dlh_r) << (HW + 1)) + WW'(dll_r);
      td7_r  <= (WW'(thh_r) << LW) + ((WW'(tlh_r) + WW'(thl_r)) << HW) + WW'(tll_r);
    end
  end

  // Stage 8: lengths product times the squared cosine, by chunks.
  always_ff @(posedge clk) begin
    if (en) begin
      c8_r   <= c7_r;
      dsq8_r <= dsq7_r;
      for (int i = 0; i < 4; i++) begin
        cp_r[i] <= CPW'(td7_r[i*HW +: HW]) * CPW'(csq_r);
      end
    end
  end

  // Stage 9: both sides of the angle compare.
  always_ff @(posedge clk) begin
    if (en) begin
      c9_r   <= c8_r;
      lhs9_r <= RHW'(dsq8_r) << 30;
      rhs9_r <= RHW'(cp_r[0]) + (RHW'(cp_r[1]) << HW) + (RHW'(cp_r[2]) << (2 * HW))
              + (RHW'(cp_r[3]) << (3 * HW));
    end
  end

  // Stage 10: result register.
  assign angle_ok = neg ? (c9_r.dot_nn || (lhs9_r <= rhs9_r))
                        : (c9_r.dot_nn && (lhs9_r >= rhs9_r));

  always_ff @(posedge clk) begin
    if (en) begin
      out_inside_res <= c9_r.res_fix || (c9_r.need && angle_ok);
    end
  end

  `PIA_ASSERT_NXT(a_cfg_starts_run, cfg_valid && cfg_ready, busy)
  `PIA_ASSERT_IMP(a_no_item_in_run, busy, !(in_valid && in_ready))
  `PIA_ASSERT_NXT(a_item_enters, in_valid && in_ready, vld_r[0])
  `PIA_ASSERT_NXT(a_stall_holds, out_valid && !out_ready, $stable(vld_r))

endmodule
